// ===== rtl/core/gso_pkg.sv =====
// Shared types, constants and saturating Q32.32 helpers for the Gram-Schmidt block.
// No dependencies; every other file in rtl/core imports this package.
package gso_pkg;

  localparam int DIM   = 8;                 // largest basis dimension
  localparam int IW    = $clog2(DIM);       // row/column index width
  localparam int AW    = 2 * IW;            // store address {row, column}
  localparam int DEPTH = 2 ** AW;
  localparam int ROW_W = 3;                 // fixed port width of row/column
  localparam int DIM_W = 4;                 // width of the dimension register

  localparam logic signed [63:0] SMAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN  = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT_RD, ST_INIT_WR,
    ST_DOT_RD, ST_DOT_MUL, ST_DOT_WAIT,
    ST_DIV_START, ST_DIV_WAIT,
    ST_SUB_RD, ST_SUB_MUL, ST_SUB_WAIT,
    ST_NORM_RD, ST_NORM_MUL, ST_NORM_WAIT, ST_NORM_END,
    ST_OUT_RD, ST_OUT_WR
  } gso_state_t;

  typedef enum logic {OW_BASIS, OW_SUB} ow_sel_t;
  typedef enum logic [1:0] {MS_DOT, MS_SUB, MS_NORM} mul_sel_t;
  typedef enum logic [1:0] {CS_MEM, CS_ONE, CS_ZERO} coef_sel_t;

  typedef struct packed {
    logic             basis_we;
    logic             basis_re;
    logic [AW-1:0]    basis_addr;
    logic             ortho_re;
    logic             ortho_we;
    logic [AW-1:0]    ortho_addr_a;
    logic [AW-1:0]    ortho_addr_b;
    ow_sel_t          ortho_sel;
    logic             mul_start;
    mul_sel_t         mul_sel;
    logic             acc_clr;
    logic             acc_add;
    logic             div_start;
    logic             mu_load;
    logic             coef_we;
    logic             coef_re;
    logic [AW-1:0]    coef_addr;
    logic             norm_we;
    logic [IW-1:0]    norm_idx;
    logic             out_load;
    logic [ROW_W-1:0] out_row;
    logic [ROW_W-1:0] out_col;
    logic             out_last;
    logic             out_deg;
    logic             out_dead;
    coef_sel_t        out_coef_sel;
  } gso_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic acc_zero;
    logic out_free;
  } gso_sts_t;

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    mag = a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic signed [63:0] sat_mag(input logic [63:0] m, input logic neg);
    if (neg) sat_mag = m[63] ? SMIN : $signed(64'd0 - m);
    else     sat_mag = m[63] ? SMAX : $signed(m);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) sat_add = a[63] ? SMIN : SMAX;
    else sat_add = s;
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) sat_sub = a[63] ? SMIN : SMAX;
    else sat_sub = s;
  endfunction

endpackage

// ===== rtl/core/gso_mul.sv =====
// Q32.32 multiplier: four 32x32 partial products accumulated in turn, then round/saturate.
// Depends on gso_pkg.
module gso_mul import gso_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] result
);

  logic         busy, fin;
  logic [1:0]   step;
  logic [63:0]  x, y;
  logic         neg;
  logic [127:0] acc;
  logic [31:0]  xs, ys;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  m;

  always_comb begin
    xs = step[1] ? x[63:32] : x[31:0];
    ys = step[0] ? y[63:32] : y[31:0];
    pp = xs * ys;
    case (step)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    m = (acc[127:96] != 32'd0) ? {64{1'b1}} : acc[95:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // acc starts at one half LSB so the sum comes out rounded
  always_ff @(posedge clk) begin
    if (start) begin
      x   <= mag(a);
      y   <= mag(b);
      neg <= a[63] ^ b[63];
      acc <= 128'h8000_0000;
    end else if (busy) begin
      acc <= acc + pp_sh;
    end else if (fin) begin
      result <= sat_mag(m, neg);
    end
  end

endmodule

// ===== rtl/core/gso_div.sv =====
// Q32.32 divider, restoring radix-2, one quotient bit per cycle, round and saturate.
// Depends on gso_pkg.
module gso_div import gso_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [63:0]        den,
  output logic               done,
  output logic signed [63:0] result
);

  logic        busy, fin;
  logic [5:0]  cnt;
  logic [63:0] rem, lo, q, den_r;
  logic        neg;
  logic [63:0] u, rsh, qr;
  logic        take;

  always_comb begin
    u    = mag(num);
    rsh  = {rem[62:0], lo[63]};
    take = rem[63] || (rsh >= den_r);
    qr   = (rem >= den_r - rem && q != {64{1'b1}}) ? q + 64'd1 : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 6'd0;
        if ({32'd0, u[63:32]} >= den) begin
          fin <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[63];
      den_r <= den;
      if ({32'd0, u[63:32]} >= den) begin
        q   <= {64{1'b1}};   // overflow: saturate, no rounding
        rem <= 64'd0;
      end else begin
        q   <= 64'd0;
        rem <= {32'd0, u[63:32]};
        lo  <= {u[31:0], 32'd0};
      end
    end else if (busy) begin
      lo  <= {lo[62:0], 1'b0};
      q   <= {q[62:0], take};
      rem <= take ? rsh - den_r : rsh;
    end else if (fin) begin
      result <= sat_mag(qr, neg);
    end
  end

endmodule

// ===== rtl/core/gso_datapath.sv =====
// Datapath: basis/ortho/coef stores, norms, accumulator, shared mul and div, output word.
// Depends on gso_pkg, gso_mul, gso_div.
module gso_datapath import gso_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  gso_cmd_t            cmd,
  input  logic signed [15:0]  entry,
  input  logic                result_stall,
  output gso_sts_t            sts,
  output logic                result_valid,
  output logic [ROW_W-1:0]    row,
  output logic [ROW_W-1:0]    column,
  output logic signed [63:0]  ortho_entry,
  output logic signed [63:0]  coefficient,
  output logic [62:0]         row_norm,
  output logic                degenerate,
  output logic                last
);

  logic signed [15:0] basis_mem [DEPTH];
  logic signed [63:0] ortho_mem [DEPTH];
  logic signed [63:0] coef_mem  [DEPTH];
  logic signed [63:0] norm      [DIM];

  logic signed [15:0] basis_q;
  logic signed [63:0] ortho_a_q, ortho_b_q, coef_q;
  logic signed [63:0] acc, mu;
  logic signed [63:0] basis_fx, ortho_wd, mul_a, mul_b, mul_res, div_res;
  logic               mul_done, div_done;

  assign basis_fx = {{16{basis_q[15]}}, basis_q, 32'd0};
  assign ortho_wd = (cmd.ortho_sel == OW_SUB) ? sat_sub(ortho_a_q, mul_res) : basis_fx;

  always_comb begin
    case (cmd.mul_sel)
      MS_DOT:  begin mul_a = basis_fx;  mul_b = ortho_b_q; end
      MS_SUB:  begin mul_a = mu;        mul_b = ortho_b_q; end
      default: begin mul_a = ortho_a_q; mul_b = ortho_a_q; end
    endcase
  end

  gso_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  gso_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .num    (acc),
    .den    (norm[cmd.norm_idx]),
    .done   (div_done),
    .result (div_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.basis_we) basis_mem[cmd.basis_addr] <= entry;
    if (cmd.basis_re) basis_q <= basis_mem[cmd.basis_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ortho_we) ortho_mem[cmd.ortho_addr_a] <= ortho_wd;
    if (cmd.ortho_re) begin
      ortho_a_q <= ortho_mem[cmd.ortho_addr_a];
      ortho_b_q <= ortho_mem[cmd.ortho_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_we) coef_mem[cmd.coef_addr] <= div_res;
    if (cmd.coef_re) coef_q <= coef_mem[cmd.coef_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.norm_we) norm[cmd.norm_idx] <= acc;
    if (cmd.mu_load) mu <= div_res;
    if (cmd.acc_clr)      acc <= 64'sd0;
    else if (cmd.acc_add) acc <= sat_add(acc, mul_res);
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      row         <= cmd.out_row;
      column      <= cmd.out_col;
      last        <= cmd.out_last;
      degenerate  <= cmd.out_deg;
      ortho_entry <= cmd.out_dead ? 64'sd0 : ortho_a_q;
      row_norm    <= cmd.out_dead ? 63'd0 : norm[cmd.norm_idx][62:0];
      if (cmd.out_dead) begin
        coefficient <= 64'sd0;
      end else begin
        case (cmd.out_coef_sel)
          CS_MEM:  coefficient <= coef_q;
          CS_ONE:  coefficient <= Q_ONE;
          default: coefficient <= 64'sd0;
        endcase
      end
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.acc_zero = (acc == 64'sd0);
  assign sts.out_free = !result_valid || !result_stall;

endmodule

// ===== rtl/core/gso_ctrl.sv =====
// Controller: load counters, dimension register, Gram-Schmidt sequencer, output walk.
// Depends on gso_pkg.
module gso_ctrl import gso_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [DIM_W-1:0] cfg_data,
  input  logic             entry_valid,
  output logic             entry_stall,
  input  gso_sts_t         sts,
  output gso_cmd_t         cmd
);

  gso_state_t       state, state_next;
  logic [DIM_W-1:0] dim;
  logic [IW-1:0]    lr, lr_next, lc, lc_next;
  logic [IW-1:0]    i, i_next, j, j_next, k, k_next;
  logic             deg_flag, deg_flag_next;
  logic [IW-1:0]    deg_row, deg_row_next;
  logic [IW-1:0]    nm1;
  logic             accept;

  always_comb begin
    if (dim == '0)                    nm1 = '0;
    else if (dim > DIM_W'(DIM))       nm1 = IW'(DIM - 1);
    else                              nm1 = IW'(dim - DIM_W'(1));
  end

  assign entry_stall = (state != ST_IDLE);
  assign accept      = entry_valid && !entry_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      dim      <= DIM_W'(DIM);
      lr       <= '0;
      lc       <= '0;
      i        <= '0;
      j        <= '0;
      k        <= '0;
      deg_flag <= 1'b0;
      deg_row  <= '0;
    end else begin
      state    <= state_next;
      lr       <= lr_next;
      lc       <= lc_next;
      i        <= i_next;
      j        <= j_next;
      k        <= k_next;
      deg_flag <= deg_flag_next;
      deg_row  <= deg_row_next;
      if (cfg_write) dim <= cfg_data;
    end
  end

  always_comb begin
    state_next    = state;
    lr_next       = lr;
    lc_next       = lc;
    i_next        = i;
    j_next        = j;
    k_next        = k;
    deg_flag_next = deg_flag;
    deg_row_next  = deg_row;
    cmd           = '0;

    cmd.ortho_addr_a = {i, j};
    cmd.ortho_addr_b = {k, j};
    cmd.basis_addr   = {i, j};
    cmd.coef_addr    = {i, j};
    cmd.norm_idx     = i;

    case (state)
      ST_IDLE: begin
        cmd.basis_addr = {lr, lc};
        if (accept) begin
          cmd.basis_we = 1'b1;
          if (lc == nm1) begin
            lc_next = '0;
            if (lr == nm1) begin
              lr_next       = '0;
              i_next        = '0;
              j_next        = '0;
              deg_flag_next = 1'b0;
              state_next    = ST_INIT_RD;
            end else begin
              lr_next = lr + 1'b1;
            end
          end else begin
            lc_next = lc + 1'b1;
          end
        end
      end
      ST_INIT_RD: begin
        cmd.basis_re = 1'b1;
        state_next   = ST_INIT_WR;
      end
      ST_INIT_WR: begin
        cmd.ortho_we  = 1'b1;
        cmd.ortho_sel = OW_BASIS;
        if (j == nm1) begin
          j_next      = '0;
          k_next      = '0;
          cmd.acc_clr = 1'b1;
          state_next  = (i == '0) ? ST_NORM_RD : ST_DOT_RD;
        end else begin
          j_next     = j + 1'b1;
          state_next = ST_INIT_RD;
        end
      end
      ST_DOT_RD: begin
        cmd.basis_re = 1'b1;
        cmd.ortho_re = 1'b1;
        state_next   = ST_DOT_MUL;
      end
      ST_DOT_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_DOT;
        state_next    = ST_DOT_WAIT;
      end
      ST_DOT_WAIT: begin
        if (sts.mul_done) begin
          cmd.acc_add = 1'b1;
          if (j == nm1) begin
            j_next     = '0;
            state_next = ST_DIV_START;
          end else begin
            j_next     = j + 1'b1;
            state_next = ST_DOT_RD;
          end
        end
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        cmd.norm_idx  = k;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        cmd.coef_addr = {i, k};
        if (sts.div_done) begin
          cmd.mu_load = 1'b1;
          cmd.coef_we = 1'b1;
          state_next  = ST_SUB_RD;
        end
      end
      ST_SUB_RD: begin
        cmd.ortho_re = 1'b1;
        state_next   = ST_SUB_MUL;
      end
      ST_SUB_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_SUB;
        state_next    = ST_SUB_WAIT;
      end
      ST_SUB_WAIT: begin
        if (sts.mul_done) begin
          cmd.ortho_we  = 1'b1;
          cmd.ortho_sel = OW_SUB;
          if (j == nm1) begin
            j_next      = '0;
            cmd.acc_clr = 1'b1;
            if (k == i - 1'b1) begin
              state_next = ST_NORM_RD;
            end else begin
              k_next     = k + 1'b1;
              state_next = ST_DOT_RD;
            end
          end else begin
            j_next     = j + 1'b1;
            state_next = ST_SUB_RD;
          end
        end
      end
      ST_NORM_RD: begin
        cmd.ortho_re = 1'b1;
        state_next   = ST_NORM_MUL;
      end
      ST_NORM_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_NORM;
        state_next    = ST_NORM_WAIT;
      end
      ST_NORM_WAIT: begin
        if (sts.mul_done) begin
          cmd.acc_add = 1'b1;
          if (j == nm1) begin
            j_next     = '0;
            state_next = ST_NORM_END;
          end else begin
            j_next     = j + 1'b1;
            state_next = ST_NORM_RD;
          end
        end
      end
      ST_NORM_END: begin
        cmd.norm_we = 1'b1;
        j_next      = '0;
        if (sts.acc_zero || i == nm1) begin
          if (sts.acc_zero) begin
            deg_flag_next = 1'b1;
            deg_row_next  = i;
          end
          i_next     = '0;
          state_next = ST_OUT_RD;
        end else begin
          i_next     = i + 1'b1;
          state_next = ST_INIT_RD;
        end
      end
      ST_OUT_RD: begin
        // read issued here; the held read data is loaded once the output word frees
        cmd.ortho_re     = 1'b1;
        cmd.coef_re      = 1'b1;
        state_next       = ST_OUT_WR;
      end
      ST_OUT_WR: begin
        cmd.out_row  = ROW_W'(i);
        cmd.out_col  = ROW_W'(j);
        cmd.out_last = (i == nm1) && (j == nm1);
        cmd.out_deg  = deg_flag && (i >= deg_row);
        cmd.out_dead = deg_flag && (i > deg_row);
        if (j > i)                             cmd.out_coef_sel = CS_ZERO;
        else if (j == i && deg_flag && i == deg_row) cmd.out_coef_sel = CS_ZERO;
        else if (j == i)                       cmd.out_coef_sel = CS_ONE;
        else                                   cmd.out_coef_sel = CS_MEM;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (j == nm1) begin
            j_next     = '0;
            i_next     = i + 1'b1;
            state_next = (i == nm1) ? ST_IDLE : ST_OUT_RD;
          end else begin
            j_next     = j + 1'b1;
            state_next = ST_OUT_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (cfg_write) begin
      lr_next = '0;
      lc_next = '0;
    end
  end

endmodule

// ===== rtl/core/gram_schmidt_orthogonalizer.sv =====
// Top level of the classical Gram-Schmidt orthogonalizer.
// Depends on gso_pkg, gso_ctrl, gso_datapath (which holds gso_mul and gso_div).
//
// Usage:
//  - Config: cfg_write with cfg_data sets the dimension n (0 acts as 1, above 8 as 8)
//    and restarts loading. Write only while the block is idle.
//  - Input channel (entry_valid / entry_stall / entry): n*n signed integer words,
//    row-major. entry_stall is low only while the block waits for input.
//  - After the last word the block computes, then sends n*n result words, row-major,
//    on the result channel (result_valid / result_stall), last set on the final one.
//  - Timing: one word loads per cycle. Compute after the last word is set by the
//    single shared multiplier (four 32x32 partial products per multiply-accumulate)
//    and the radix-2 divider (one division per coefficient). Each output word is
//    read in ST_OUT_RD, then loaded in ST_OUT_WR once the result channel is free.
//  - A stalled result word holds; the sequencer waits on it, nothing is dropped.
//  - Reset (rst, synchronous, active high): dimension 8, load position 0, idle.
//    Stores are not cleared; every entry that is used is written before it is read.
//  - A row with zero norm marks the run degenerate; later rows come out as zeros.
module gram_schmidt_orthogonalizer import gso_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [DIM_W-1:0]   cfg_data,
  input  logic               entry_valid,
  output logic               entry_stall,
  input  logic signed [15:0] entry,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [ROW_W-1:0]   row,
  output logic [ROW_W-1:0]   column,
  output logic signed [63:0] ortho_entry,
  output logic signed [63:0] coefficient,
  output logic [62:0]        row_norm,
  output logic               degenerate,
  output logic               last
);

  gso_cmd_t cmd;
  gso_sts_t sts;

  gso_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .entry_valid (entry_valid),
    .entry_stall (entry_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  gso_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .entry        (entry),
    .result_stall (result_stall),
    .sts          (sts),
    .result_valid (result_valid),
    .row          (row),
    .column       (column),
    .ortho_entry  (ortho_entry),
    .coefficient  (coefficient),
    .row_norm     (row_norm),
    .degenerate   (degenerate),
    .last         (last)
  );

  // never overwrite a word the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output word overwritten");

  // after the final word is queued the block takes input again
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_last) |=> !entry_stall)
    else $error("not idle after final word");

  // accumulator only takes a finished product
  a_acc_on_done: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_add |-> sts.mul_done)
    else $error("accumulate without product");

  // quotient consumed only when the divider finishes
  a_mu_on_done: assert property (@(posedge clk) disable iff (rst)
    cmd.mu_load |-> sts.div_done)
    else $error("coefficient taken before division done");

endmodule
